// ===== rtl/nwdg_pkg.sv =====
`default_nettype none

package nwdg_pkg;

    localparam int MS_W     = 32;
    localparam int MINUTE_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SYNC = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NIGHT_ENABLE  = 3'd0,
        REG_WINDOW_START  = 3'd1,
        REG_WINDOW_END    = 3'd2,
        REG_TRUST_WINDOW  = 3'd3,
        REG_RESYNC_PERIOD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                night_enable;
        logic [MINUTE_W-1:0] window_start_minute;
        logic [MINUTE_W-1:0] window_end_minute;
        logic [MS_W-1:0]     trust_window_ms;
        logic [MS_W-1:0]     resync_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic            window_latched;
        logic            dim_active;
        logic            dim_held;
        logic            resync_valid;
        logic [MS_W-1:0] last_resync_stamp;
        logic [MS_W-1:0] last_sync_stamp;
        logic            sync_seen;
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [MS_W-1:0]     now_ms;
        logic [MINUTE_W-1:0] minute_of_day;
        logic                time_valid;
    } t_item;

    typedef struct packed {
        logic night_active;
        logic night_held;
        logic resync_request;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/night_window_dimming_gate.sv =====
// An accepted request is held in the input register; its result is registered in the result register.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or its result is taken in the same cycle.
// Reset (synchronous, active low): clears configuration, window and sync state,
// and both pipeline valid flags.
`default_nettype none

module night_window_dimming_gate
    import nwdg_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] now_ms, [42:32] minute_of_day, [43] time_valid, [47:44] zero
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  wire                   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // [0] night_active, [1] night_held, [2] resync_request, [7:3] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_NIGHT_ENABLE:  r_cfg.night_enable        <= i_cfg_data[0];
                REG_WINDOW_START:  r_cfg.window_start_minute <= i_cfg_data[MINUTE_W-1:0];
                REG_WINDOW_END:    r_cfg.window_end_minute   <= i_cfg_data[MINUTE_W-1:0];
                REG_TRUST_WINDOW:  r_cfg.trust_window_ms     <= i_cfg_data[MS_W-1:0];
                REG_RESYNC_PERIOD: r_cfg.resync_interval_ms  <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.op            <= t_op'(s_axis_tuser);
            r_item.now_ms        <= s_axis_tdata[MS_W-1:0];
            r_item.minute_of_day <= s_axis_tdata[MS_W+MINUTE_W-1:MS_W];
            r_item.time_valid    <= s_axis_tdata[MS_W+MINUTE_W];
        end
    end

    nwdg_decide u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, r_result.resync_request,
                            r_result.night_held, r_result.night_active};

endmodule

`default_nettype wire

// ===== rtl/nwdg_decide.sv =====
`default_nettype none

module nwdg_decide
    import nwdg_pkg::*;
(
    input  wire t_cfg    i_cfg,
    input  wire t_state  i_state,
    input  wire t_item   i_item,
    output t_state       o_state,
    output t_result      o_result
);

    logic            in_window;
    logic [MS_W-1:0] sync_age;
    logic [MS_W-1:0] resync_age;
    logic            trusted;
    logic            request;

    always_comb begin
        if (i_cfg.window_start_minute == i_cfg.window_end_minute) begin
            in_window = 1'b0;
        end else if (i_cfg.window_start_minute < i_cfg.window_end_minute) begin
            in_window = (i_item.minute_of_day >= i_cfg.window_start_minute) &&
                        (i_item.minute_of_day <  i_cfg.window_end_minute);
        end else begin
            in_window = (i_item.minute_of_day >= i_cfg.window_start_minute) ||
                        (i_item.minute_of_day <  i_cfg.window_end_minute);
        end
    end

    assign sync_age   = i_item.now_ms - i_state.last_sync_stamp;
    assign resync_age = i_item.now_ms - i_state.last_resync_stamp;
    assign trusted    = i_state.sync_seen && (sync_age <= i_cfg.trust_window_ms);

    always_comb begin
        o_state = i_state;
        request = 1'b0;
        if (i_item.op == OP_SYNC) begin
            o_state.last_sync_stamp = i_item.now_ms;
            o_state.sync_seen       = 1'b1;
        end else if (!i_cfg.night_enable || !i_item.time_valid || !in_window) begin
            o_state.window_latched    = 1'b0;
            o_state.dim_active        = 1'b0;
            o_state.dim_held          = 1'b0;
            o_state.resync_valid      = 1'b0;
            o_state.last_resync_stamp = '0;
        end else if (i_state.window_latched || trusted) begin
            o_state.window_latched = 1'b1;
            o_state.dim_active     = 1'b1;
            o_state.dim_held       = 1'b0;
        end else begin
            o_state.dim_active = 1'b0;
            o_state.dim_held   = 1'b1;
            if (!i_state.resync_valid || (resync_age >= i_cfg.resync_interval_ms)) begin
                o_state.last_resync_stamp = i_item.now_ms;
                o_state.resync_valid      = 1'b1;
                request                   = 1'b1;
            end
        end
        o_result.night_active   = o_state.dim_active;
        o_result.night_held     = o_state.dim_held;
        o_result.resync_request = request;
    end

endmodule

`default_nettype wire
